[rtl/core/mva_pkg.sv]
package mva_pkg;

    localparam int WORD_BITS = 64;
    localparam int RES_BITS  = 63;
    localparam int CMD_BITS  = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NEGATE     = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_SUBTRACT   = 3'd2,
        CMD_MULTIPLY   = 3'd3,
        CMD_MUL_SCALAR = 3'd4
    } cmd_t;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_SCALAR  = 1'b1;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [WORD_BITS-1:0] a_sh;
        logic [WORD_BITS-1:0] b_sh;
        logic [WORD_BITS-1:0] ra;
        logic [WORD_BITS-1:0] rb;
    } red_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y_sh;
        logic [WORD_BITS-1:0] acc;
        logic [WORD_BITS-1:0] b;
    } mul_t;

    function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                      input logic [WORD_BITS-1:0] y,
                                                      input logic [WORD_BITS-1:0] q);
        logic [WORD_BITS-1:0] s;
        s = x + y;
        return (s >= q) ? s - q : s;
    endfunction

endpackage

[rtl/core/mva_red_cell.sv]
module mva_red_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [mva_pkg::WORD_BITS-1:0] q,
    input  logic                         in_valid,
    input  mva_pkg::red_t                in_data,
    output logic                         out_valid,
    output mva_pkg::red_t                out_data
);

    logic          valid_reg;
    mva_pkg::red_t data_reg;
    mva_pkg::red_t data_next;
    logic [mva_pkg::WORD_BITS-1:0] ta;
    logic [mva_pkg::WORD_BITS-1:0] tb;

    // One restoring step of the remainder for each operand, most significant bit first.
    always_comb begin
        ta = {in_data.ra[mva_pkg::WORD_BITS-2:0], in_data.a_sh[mva_pkg::WORD_BITS-1]};
        tb = {in_data.rb[mva_pkg::WORD_BITS-2:0], in_data.b_sh[mva_pkg::WORD_BITS-1]};
        data_next      = in_data;
        data_next.a_sh = {in_data.a_sh[mva_pkg::WORD_BITS-2:0], 1'b0};
        data_next.b_sh = {in_data.b_sh[mva_pkg::WORD_BITS-2:0], 1'b0};
        data_next.ra   = (ta >= q) ? ta - q : ta;
        data_next.rb   = (tb >= q) ? tb - q : tb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/mva_mul_cell.sv]
module mva_mul_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [mva_pkg::WORD_BITS-1:0] q,
    input  logic                         in_valid,
    input  mva_pkg::mul_t                in_data,
    output logic                         out_valid,
    output mva_pkg::mul_t                out_data
);

    logic          valid_reg;
    mva_pkg::mul_t data_reg;
    mva_pkg::mul_t data_next;
    logic [mva_pkg::WORD_BITS-1:0] dbl;

    // Double the accumulator, then add x when the current multiplier bit is set.
    always_comb begin
        dbl            = mva_pkg::add_mod(in_data.acc, in_data.acc, q);
        data_next      = in_data;
        data_next.y_sh = {in_data.y_sh[mva_pkg::WORD_BITS-2:0], 1'b0};
        data_next.acc  = in_data.y_sh[mva_pkg::WORD_BITS-1] ?
                         mva_pkg::add_mod(dbl, in_data.x, q) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/modular_vector_alu_unit.sv]
// Element-wise modular negate, add, subtract, multiply and multiply by a
// configured scalar on 63-bit residues under a configured modulus. One
// transaction is accepted every cycle while the output is free to move; each
// result passes through a chain of 64 remainder cells that reduce both
// operands (or the scalar) modulo q, a chain of 64 double-and-add cells that
// form the product one multiplier bit per cell, and the output register. The
// whole chain stalls together when a result waits at the output. Configuration
// is to be written by the user only while no transaction is in flight; the
// block itself does not enforce it.
module modular_vector_alu_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [mva_pkg::WORD_BITS-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mva_pkg::CMD_BITS-1:0]  s_command,
    input  logic [mva_pkg::RES_BITS-1:0]  s_operand_a,
    input  logic [mva_pkg::RES_BITS-1:0]  s_operand_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mva_pkg::RES_BITS-1:0]  m_residue_out
);

    localparam int N = mva_pkg::WORD_BITS;

    logic [mva_pkg::RES_BITS-1:0]  modulus_reg;
    logic [N-1:0]                  scalar_reg;
    logic [N-1:0]                  q;
    logic                          en;
    logic                          m_valid_reg;
    logic [mva_pkg::RES_BITS-1:0]  residue_reg;
    logic [mva_pkg::RES_BITS-1:0]  residue_next;

    logic          red_valid [0:N];
    mva_pkg::red_t red_data  [0:N];
    logic          mul_valid [0:N];
    mva_pkg::mul_t mul_data  [0:N];

    assign q         = {1'b0, modulus_reg};
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mva_pkg::RES_BITS'(2);
            scalar_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == mva_pkg::CFG_MODULUS) begin
                modulus_reg <= cfg_data[mva_pkg::RES_BITS-1:0];
            end else begin
                scalar_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        red_valid[0]     = s_valid;
        red_data[0].cmd  = s_command;
        red_data[0].a_sh = {1'b0, s_operand_a};
        red_data[0].b_sh = (s_command == mva_pkg::CMD_MUL_SCALAR) ? scalar_reg
                                                                  : {1'b0, s_operand_b};
        red_data[0].ra   = '0;
        red_data[0].rb   = '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_red
        mva_red_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .q         (q),
            .in_valid  (red_valid[i]),
            .in_data   (red_data[i]),
            .out_valid (red_valid[i+1]),
            .out_data  (red_data[i+1])
        );
    end

    always_comb begin
        mul_valid[0]     = red_valid[N];
        mul_data[0].cmd  = red_data[N].cmd;
        mul_data[0].x    = red_data[N].ra;
        mul_data[0].y_sh = red_data[N].rb;
        mul_data[0].acc  = '0;
        mul_data[0].b    = red_data[N].rb;
    end

    for (genvar i = 0; i < N; i++) begin : g_mul
        mva_mul_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .q         (q),
            .in_valid  (mul_valid[i]),
            .in_data   (mul_data[i]),
            .out_valid (mul_valid[i+1]),
            .out_data  (mul_data[i+1])
        );
    end

    always_comb begin
        logic [N-1:0] a;
        logic [N-1:0] b;
        logic [N-1:0] r;
        a = mul_data[N].x;
        b = mul_data[N].b;
        case (mul_data[N].cmd) inside
            mva_pkg::CMD_NEGATE:   r = (a == '0) ? '0 : q - a;
            mva_pkg::CMD_ADD:      r = mva_pkg::add_mod(a, b, q);
            mva_pkg::CMD_SUBTRACT: r = (a >= b) ? a - b : a + (q - b);
            mva_pkg::CMD_MULTIPLY, mva_pkg::CMD_MUL_SCALAR: r = mul_data[N].acc;
            default:               r = '0;
        endcase
        if (q < N'(2)) begin
            r = '0;
        end
        residue_next = r[mva_pkg::RES_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mul_valid[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            residue_reg <= residue_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_residue_out = residue_reg;

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (residue_reg < modulus_reg) || (modulus_reg < 2))
        else $error("result residue not below the modulus");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(mul_valid[N]) && $stable(red_valid[N]))
        else $error("chain moved while the output was stalled");

    a_input_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("transaction accepted while the chain was stalled");

endmodule

[test/modular_vector_alu_unit_tb.sv]
module modular_vector_alu_unit_tb;

    localparam int LATENCY = 130;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [mva_pkg::WORD_BITS-1:0] cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [mva_pkg::CMD_BITS-1:0]  s_command;
    logic [mva_pkg::RES_BITS-1:0]  s_operand_a;
    logic [mva_pkg::RES_BITS-1:0]  s_operand_b;
    logic                          m_valid;
    logic                          m_ready;
    logic [mva_pkg::RES_BITS-1:0]  m_residue_out;

    modular_vector_alu_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_residue_out(m_residue_out)
    );

    typedef struct {
        logic [mva_pkg::CMD_BITS-1:0] cmd;
        logic [mva_pkg::RES_BITS-1:0] a;
        logic [mva_pkg::RES_BITS-1:0] b;
        bit                           known;
        logic [mva_pkg::RES_BITS-1:0] res;
    } vec_row_t;

    logic [63:0]                  cur_q;
    logic [63:0]                  cur_scalar;
    logic [mva_pkg::RES_BITS-1:0] residue_queue[$];
    int                           mismatches;
    int                           sent;
    int                           received;
    bit                           calm;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y, logic [63:0] q);
        logic [63:0] s;
        s = x + y;
        return (s >= q) ? s - q : s;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] q);
        logic [63:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--) begin
            acc = mod_add(acc, acc, q);
            if (y[i]) begin
                acc = mod_add(acc, x, q);
            end
        end
        return acc;
    endfunction

    function automatic logic [mva_pkg::RES_BITS-1:0] predict_residue(
        logic [mva_pkg::CMD_BITS-1:0] cmd,
        logic [mva_pkg::RES_BITS-1:0] a_in,
        logic [mva_pkg::RES_BITS-1:0] b_in);
        logic [63:0] q;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        q = cur_q;
        r = '0;
        if (q >= 2) begin
            a = {1'b0, a_in} % q;
            b = {1'b0, b_in} % q;
            case (cmd)
                mva_pkg::CMD_NEGATE: begin
                    r = (a == 0) ? 64'd0 : q - a;
                end
                mva_pkg::CMD_ADD: begin
                    r = mod_add(a, b, q);
                end
                mva_pkg::CMD_SUBTRACT: begin
                    r = (a >= b) ? a - b : a + (q - b);
                end
                mva_pkg::CMD_MULTIPLY: begin
                    r = mod_mul(a, b, q);
                end
                mva_pkg::CMD_MUL_SCALAR: begin
                    r = mod_mul(a, cur_scalar % q, q);
                end
                default: begin
                    r = '0;
                end
            endcase
        end
        return r[mva_pkg::RES_BITS-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [mva_pkg::RES_BITS-1:0] got,
                                   logic [mva_pkg::RES_BITS-1:0] want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (residue_queue.size() == 0) begin
                report_mismatch("unexpected transaction", m_residue_out, '0);
            end else begin
                if (m_residue_out !== residue_queue[0]) begin
                    report_mismatch("residue_out", m_residue_out, residue_queue[0]);
                end
                void'(residue_queue.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
        end
    end

    task automatic write_reg(logic idx, logic [63:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        if (idx == mva_pkg::CFG_MODULUS) begin
            cur_q = {1'b0, value[62:0]};
        end else begin
            cur_scalar = value;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (residue_queue.size() != 0) begin
            @(negedge aclk);
        end
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    task automatic send_item(logic [mva_pkg::CMD_BITS-1:0] cmd,
                             logic [mva_pkg::RES_BITS-1:0] a,
                             logic [mva_pkg::RES_BITS-1:0] b, bit known,
                             logic [mva_pkg::RES_BITS-1:0] res);
        while (!calm && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_command   <= cmd;
        s_operand_a <= a;
        s_operand_b <= b;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        residue_queue.push_back(known ? res : predict_residue(cmd, a, b));
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [mva_pkg::RES_BITS-1:0] rand_res();
        logic [mva_pkg::RES_BITS-1:0] v;
        v = mva_pkg::RES_BITS'({$urandom, $urandom});
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = v % 16;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [mva_pkg::RES_BITS-1:0] rand_below(logic [63:0] q);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = q - 1;
            default: v = v % q;
        endcase
        return v[mva_pkg::RES_BITS-1:0];
    endfunction

    function automatic logic [63:0] rand_modulus();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'h7FFF_FFFF_FFFF_FFFF;
            1: v = 64'(2 + $urandom_range(20));
            2: v = 64'($urandom_range(1));
            3: v = {1'b1, v[62:0]};
            default: ;
        endcase
        return v;
    endfunction

    vec_row_t directed[] = '{
        '{mva_pkg::CMD_NEGATE,     63'd0, 63'd0, 1'b1, 63'd0},
        '{mva_pkg::CMD_NEGATE,     63'd1, 63'd0, 1'b1, 63'd1},
        '{mva_pkg::CMD_ADD,        63'd1, 63'd1, 1'b1, 63'd0},
        '{mva_pkg::CMD_SUBTRACT,   63'd0, 63'd1, 1'b1, 63'd1},
        '{mva_pkg::CMD_MULTIPLY,   63'd1, 63'd1, 1'b1, 63'd1},
        '{mva_pkg::CMD_MUL_SCALAR, '1,    '1,    1'b1, 63'd0},
        '{3'd5,                    '1,    '1,    1'b1, 63'd0},
        '{3'd7,                    '1,    '1,    1'b1, 63'd0}
    };

    vec_row_t extremes[] = '{
        '{mva_pkg::CMD_NEGATE,     63'd0, 63'd0, 1'b1, 63'd0},
        '{mva_pkg::CMD_NEGATE,     63'd1, 63'd0, 1'b0, 63'd0},
        '{mva_pkg::CMD_ADD,        '1,    '1,    1'b0, 63'd0},
        '{mva_pkg::CMD_ADD,        63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFE,
          1'b0, 63'd0},
        '{mva_pkg::CMD_SUBTRACT,   63'd0, 63'h7FFF_FFFF_FFFF_FFFE, 1'b0, 63'd0},
        '{mva_pkg::CMD_SUBTRACT,   '1,    63'd0, 1'b0, 63'd0},
        '{mva_pkg::CMD_MULTIPLY,   63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFE,
          1'b0, 63'd0},
        '{mva_pkg::CMD_MULTIPLY,   '1,    63'h5555_5555_5555_5555, 1'b0, 63'd0},
        '{mva_pkg::CMD_MUL_SCALAR, 63'h7FFF_FFFF_FFFF_FFFE, 63'd3, 1'b0, 63'd0},
        '{mva_pkg::CMD_MUL_SCALAR, '1,    '1,    1'b0, 63'd0},
        '{3'd6,                    63'd5, 63'd9, 1'b1, 63'd0}
    };

    initial begin
        #20_000_000;
        $display("modular_vector_alu_unit regression: fail");
        $finish;
    end

    initial begin
        int phase;
        int burst;
        logic [mva_pkg::CMD_BITS-1:0] cmd;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        mismatches = 0;
        sent = 0;
        received = 0;
        calm = 1'b0;
        cur_q = 2;
        cur_scalar = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i].cmd, directed[i].a, directed[i].b,
                      directed[i].known, directed[i].res);
        end
        drain();
        write_reg(mva_pkg::CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(mva_pkg::CFG_SCALAR, 64'hFFFF_FFFF_FFFF_FFFF);
        foreach (extremes[i]) begin
            send_item(extremes[i].cmd, extremes[i].a, extremes[i].b,
                      extremes[i].known, extremes[i].res);
        end
        drain();
        write_reg(mva_pkg::CFG_MODULUS, 64'd1);
        send_item(mva_pkg::CMD_MULTIPLY, 63'd7, 63'd9, 1'b1, 63'd0);
        send_item(mva_pkg::CMD_NEGATE, 63'd7, 63'd9, 1'b1, 63'd0);
        drain();

        for (phase = 0; phase < 22; phase++) begin
            write_reg(mva_pkg::CFG_MODULUS, rand_modulus());
            write_reg(mva_pkg::CFG_SCALAR, (phase == 3) ? 64'd0 : {$urandom, $urandom});
            calm = (phase == 10);
            for (burst = 0; burst < 50; burst++) begin
                cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                                : 3'($urandom_range(4));
                if ($urandom_range(9) == 0 || cur_q < 2) begin
                    send_item(cmd, rand_res(), rand_res(), 1'b0, '0);
                end else begin
                    send_item(cmd, rand_below(cur_q), rand_below(cur_q), 1'b0, '0);
                end
            end
            calm = 1'b0;
            drain();
        end

        $display("covered %0d transactions sent, %0d results, 22 random settings", sent,
                 received);
        $display("all commands, unused codes, wide and degenerate moduli, scalar extremes");
        if (mismatches == 0 && residue_queue.size() == 0) begin
            $display("modular_vector_alu_unit regression: pass");
        end else begin
            $display("modular_vector_alu_unit regression: fail");
        end
        $finish;
    end
endmodule

[modular_vector_alu_unit.f]
rtl/core/mva_pkg.sv
rtl/core/mva_red_cell.sv
rtl/core/mva_mul_cell.sv
rtl/core/modular_vector_alu_unit.sv
test/modular_vector_alu_unit_tb.sv
